// ----- design/fta_pkg.sv -----
package fta_pkg;

  localparam int WINDOW     = 100;
  localparam int CNT_W      = $clog2(WINDOW + 1);
  localparam int SLOT_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int STAMP_W    = 32;
  localparam int FRAC_W     = 8;
  localparam int SUM_W      = 39;
  localparam int MEAN_W     = STAMP_W + FRAC_W;
  localparam int RATE_W     = 16;
  localparam int ACC_W      = STAMP_W + 1;
  localparam int DIV_W      = SUM_W + FRAC_W;
  localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [STAMP_W-1:0] TPS_RESET  = 32'd1000;
  localparam logic [STAMP_W-1:0] INIT_RESET = 32'd4352;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELTA    = 1'd1;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [STAMP_W-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic [MEAN_W-1:0] average_delta;
    logic [RATE_W-1:0] frame_rate;
    logic              sample_accepted;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLUSH,
    ST_DIFF,
    ST_TEST,
    ST_EVICT,
    ST_INSERT,
    ST_SECOND,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic capture;
    logic flush;
    logic diff;
    logic test;
    logic evict;
    logic insert;
    logic second;
    logic div_start;
    logic div_take;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/frame_time_averager_unit.sv -----
// channel   direction  handshake              payload
// in_       input      in_valid / in_ready    in_item_t  {kind, timestamp}
// out_      output     out_valid / out_ready  out_item_t {average_delta, frame_rate,
//                                                         sample_accepted}
// cfg_      input      cfg_we                 cfg_index, cfg_data
//
// One item at a time. A flush passes through the flush and finish steps; a frame
// passes through diff, test, evict, insert and second, then waits in divide for the
// restoring divider to deliver its quotient bits, then finish; divide is skipped when
// the window is empty after the item. The result turns valid in the cycle in_ready
// returns. The block stalls before loading a new result only if the output register
// is still full. Reset is synchronous, active low, with no clearing pass.
module frame_time_averager_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fta_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fta_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fta_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fta_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fta_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ----- design/fta_divider.sv -----
module fta_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [fta_pkg::DIV_W-1:0]  dividend,
  input  logic [fta_pkg::CNT_W-1:0]  divisor,
  output logic                       done,
  output logic [fta_pkg::DIV_W-1:0]  quotient
);
  import fta_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     den_r, den_nxt;
  logic [CNT_W-1:0]     rem_r, rem_nxt;
  logic [DIV_W-1:0]     quo_r, quo_nxt;
  logic [CNT_W:0]       shifted;
  logic [CNT_W:0]       trial;

  // restoring division, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_W);
      den_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (!trial[CNT_W]) begin
        rem_nxt = trial[CNT_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r <= den_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- design/fta_ctrl.sv -----
module fta_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_kind,
  output logic          in_ready,
  input  fta_pkg::sts_t sts,
  output fta_pkg::cmd_t cmd
);
  import fta_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_kind == KIND_FLUSH) ? ST_FLUSH : ST_DIFF;
        end
      end
      ST_FLUSH:  state_nxt = ST_FINISH;
      ST_DIFF:   state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_EVICT;
      ST_EVICT:  state_nxt = ST_INSERT;
      ST_INSERT: state_nxt = ST_SECOND;
      ST_SECOND: state_nxt = sts.cnt_zero ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_FLUSH:  cmd.flush  = 1'b1;
      ST_DIFF:   cmd.diff   = 1'b1;
      ST_TEST:   cmd.test   = 1'b1;
      ST_EVICT:  cmd.evict  = 1'b1;
      ST_INSERT: cmd.insert = 1'b1;
      ST_SECOND: begin
        cmd.second    = 1'b1;
        cmd.div_start = !sts.cnt_zero;
      end
      ST_DIVIDE: cmd.div_take = sts.div_done;
      ST_FINISH: cmd.load_out = !sts.out_busy;
      default:   cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- design/fta_datapath.sv -----
module fta_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fta_pkg::in_item_t              in_data,
  input  logic                           cfg_we,
  input  logic [fta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fta_pkg::CFG_DATA_W-1:0] cfg_data,
  input  fta_pkg::cmd_t                  cmd,
  output fta_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output fta_pkg::out_item_t             out_data
);
  import fta_pkg::*;

  localparam int PSLOT_W = SLOT_W + 1;

  logic [STAMP_W-1:0] tps_r, tps_nxt;
  logic [STAMP_W-1:0] init_r, init_nxt;
  logic [STAMP_W-1:0] last_stamp_r, last_stamp_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [SLOT_W-1:0]  oldest_r, oldest_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [MEAN_W-1:0]  mean_r, mean_nxt;
  logic [RATE_W-1:0]  frames_r, frames_nxt;
  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [RATE_W-1:0]  rate_r, rate_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [STAMP_W-1:0] d_r, d_nxt;
  logic [MEAN_W-1:0]  diff_r, diff_nxt;
  logic               ok_r, ok_nxt;
  out_item_t          out_r, out_nxt;

  logic [STAMP_W-1:0] win_mem [WINDOW];
  logic [STAMP_W-1:0] old_r;

  logic               full;
  logic [MEAN_W-1:0]  scaled;
  logic [PSLOT_W-1:0] pslot;
  logic [SLOT_W-1:0]  wr_slot;
  logic               mem_we;
  logic               div_done;
  logic [DIV_W-1:0]   quotient;

  assign full   = (count_r == CNT_W'(WINDOW));
  assign scaled = {d_r, {FRAC_W{1'b0}}};
  assign pslot  = {1'b0, oldest_r} + PSLOT_W'(count_r);

  always_comb begin
    if (full) begin
      wr_slot = oldest_r;
    end else if (pslot >= PSLOT_W'(WINDOW)) begin
      wr_slot = SLOT_W'(pslot - PSLOT_W'(WINDOW));
    end else begin
      wr_slot = pslot[SLOT_W-1:0];
    end
  end

  assign mem_we = cmd.insert && ok_r;

  always_comb begin
    tps_nxt        = tps_r;
    init_nxt       = init_r;
    last_stamp_nxt = last_stamp_r;
    count_nxt      = count_r;
    oldest_nxt     = oldest_r;
    sum_nxt        = sum_r;
    mean_nxt       = mean_r;
    frames_nxt     = frames_r;
    acc_nxt        = acc_r;
    rate_nxt       = rate_r;
    d_nxt          = d_r;
    diff_nxt       = diff_r;
    ok_nxt         = ok_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_nxt  = cfg_data[STAMP_W-1:0];
        CFG_INITIAL_DELTA:    init_nxt = cfg_data[STAMP_W-1:0];
        default:              tps_nxt  = tps_r;
      endcase
    end

    if (cmd.capture) begin
      d_nxt          = in_data.timestamp - last_stamp_r;
      last_stamp_nxt = in_data.timestamp;
    end

    if (cmd.flush) begin
      mean_nxt   = MEAN_W'(init_r);
      count_nxt  = '0;
      oldest_nxt = '0;
      sum_nxt    = '0;
      frames_nxt = '0;
      acc_nxt    = '0;
      rate_nxt   = '0;
      ok_nxt     = 1'b0;
    end

    if (cmd.diff) begin
      diff_nxt = (scaled >= mean_r) ? scaled - mean_r : mean_r - scaled;
    end

    if (cmd.test) begin
      ok_nxt = diff_r < {tps_r, {FRAC_W{1'b0}}};
    end

    if (cmd.evict && ok_r && full) begin
      sum_nxt = sum_r - SUM_W'(old_r);
    end

    if (cmd.insert) begin
      if (ok_r) begin
        sum_nxt = sum_r + SUM_W'(d_r);
        if (full) begin
          oldest_nxt = (oldest_r == SLOT_W'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      if (frames_r != {RATE_W{1'b1}}) begin
        frames_nxt = frames_r + 1'b1;
      end
      acc_nxt = acc_r + ACC_W'(d_r);
    end

    if (cmd.second) begin
      if (acc_r > ACC_W'(tps_r)) begin
        rate_nxt   = frames_r;
        frames_nxt = '0;
        acc_nxt    = '0;
      end
      if (count_r == '0) begin
        mean_nxt = '0;
      end
    end

    if (cmd.div_take) begin
      mean_nxt = quotient[MEAN_W-1:0];
    end
  end

  // output register: the controller only loads it once the previous result is gone
  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_nxt.average_delta   = mean_r;
      out_nxt.frame_rate      = rate_r;
      out_nxt.sample_accepted = ok_r;
      out_valid_nxt           = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r        <= TPS_RESET;
      init_r       <= INIT_RESET;
      last_stamp_r <= '0;
      count_r      <= '0;
      oldest_r     <= '0;
      sum_r        <= '0;
      mean_r       <= '0;
      frames_r     <= '0;
      acc_r        <= '0;
      rate_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      tps_r        <= tps_nxt;
      init_r       <= init_nxt;
      last_stamp_r <= last_stamp_nxt;
      count_r      <= count_nxt;
      oldest_r     <= oldest_nxt;
      sum_r        <= sum_nxt;
      mean_r       <= mean_nxt;
      frames_r     <= frames_nxt;
      acc_r        <= acc_nxt;
      rate_r       <= rate_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    diff_r <= diff_nxt;
    ok_r   <= ok_nxt;
    out_r  <= out_nxt;
  end

  // window store; oldest entry is read ahead, settled long before eviction
  always_ff @(posedge clk) begin
    if (mem_we) begin
      win_mem[wr_slot] <= d_r;
    end
    old_r <= win_mem[oldest_r];
  end

  fta_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend ({sum_r, {FRAC_W{1'b0}}}),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (quotient)
  );

  assign sts.cnt_zero = (count_r == '0);
  assign sts.div_done = div_done;
  assign sts.out_busy = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- design/fta_checker.sv -----
module fta_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input fta_pkg::out_item_t out_data
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // one item in flight at a time
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in progress");

  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("block not ready for input once a result is posted");

endmodule

bind frame_time_averager_unit fta_checker u_fta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
